>>> hw/rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared constants, operation and status codes, and the result record of the
// minimum-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

   localparam int DEPTH_DEFAULT      = 64;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 7;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] top_value;
      logic signed [VALUE_W-1:0] min_value;
      logic [FILL_W-1:0]         fill_count;
      logic                      is_empty;
   } rsp_type;

endpackage

>>> hw/rtl/mts_req_if.sv
// ----------------------------------------------------------------------------
// mts_req_if
// Request channel of the minimum-tracking stack: push or pop with a value.
// ----------------------------------------------------------------------------
interface mts_req_if;
   import mts_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink (input valid, input cmd, input value, output ready);

endinterface

>>> hw/rtl/mts_rsp_if.sv
// ----------------------------------------------------------------------------
// mts_rsp_if
// Response channel of the minimum-tracking stack: status, top, minimum, count.
// ----------------------------------------------------------------------------
interface mts_rsp_if;
   import mts_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [VALUE_W-1:0] top_value;
   logic signed [VALUE_W-1:0] min_value;
   logic [FILL_W-1:0]         fill_count;
   logic                      is_empty;

   modport source (output valid, output status, output top_value, output min_value,
                   output fill_count, output is_empty, input ready);
   modport sink (input valid, input status, input top_value, input min_value,
                 input fill_count, input is_empty, output ready);

endinterface

>>> hw/rtl/mts_store.sv
// ----------------------------------------------------------------------------
// mts_store
// Entry memory: each word holds a stacked value and the running minimum at
// that depth. One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mts_store #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32,
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  logic [2*DATA_WIDTH-1:0] wr_data,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   output logic [2*DATA_WIDTH-1:0] rd_data
);

   logic [2*DATA_WIDTH-1:0] entry_mem [DEPTH];
   logic [2*DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/mts_out_buf.sv
// ----------------------------------------------------------------------------
// mts_out_buf
// Two-deep response buffer: an output register backed by a skid register, so
// the controller can start on the next transaction while a response waits.
// ----------------------------------------------------------------------------
module mts_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             res_valid,
   input  mts_pkg::rsp_type res,
   output logic             space_ok,
   mts_rsp_if.source        rsp
);
   import mts_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    taking;

   assign taking = out_valid_ff && rsp.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (taking) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (res_valid) begin
         if (!out_valid_in) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // A new transaction is only started when the skid register is free, so
   // its response always finds room.
   assign space_ok       = !skid_valid_ff;
   assign rsp.valid      = out_valid_ff;
   assign rsp.status     = out_ff.status;
   assign rsp.top_value  = out_ff.top_value;
   assign rsp.min_value  = out_ff.min_value;
   assign rsp.fill_count = out_ff.fill_count;
   assign rsp.is_empty   = out_ff.is_empty;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a response while the output is empty");

   a_no_buffer_overrun: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !skid_valid_ff)
      else $error("response arrived with both buffer registers full");
`endif

endmodule

>>> hw/rtl/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl
// Stack controller: keeps the entry count and the top entry with its minimum
// in registers, writes pushes to the entry memory and refills the top
// register from memory after a pop.
// ----------------------------------------------------------------------------
module mts_ctrl #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32,
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   mts_req_if.sink                 req,
   input  logic                    space_ok,
   output logic                    res_valid,
   output mts_pkg::rsp_type        res,
   output logic                    wr_en,
   output logic [AW-1:0]           wr_addr,
   output logic [2*DATA_WIDTH-1:0] wr_data,
   output logic                    rd_en,
   output logic [AW-1:0]           rd_addr,
   input  logic [2*DATA_WIDTH-1:0] rd_data
);
   import mts_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   localparam logic ST_IDLE     = 1'b0;
   localparam logic ST_POP_WAIT = 1'b1;

   logic                         state_ff, state_in;
   logic [CW-1:0]                sp_ff, sp_in;
   logic signed [DATA_WIDTH-1:0] top_ff, top_in;
   logic signed [DATA_WIDTH-1:0] min_ff, min_in;

   logic                         accept;
   logic                         is_full;
   logic                         is_zero;
   logic signed [DATA_WIDTH-1:0] push_val;
   logic signed [DATA_WIDTH-1:0] push_min;
   logic [CW-1:0]                sp_dec;
   logic [CW-1:0]                sp_dec2;

   logic [STATUS_W-1:0]          res_status;
   logic signed [DATA_WIDTH-1:0] res_top;
   logic signed [DATA_WIDTH-1:0] res_min;
   logic [CW-1:0]                res_cnt;
   logic                         res_empty;
   logic signed [VALUE_W-1:0]    res_top_ext;
   logic signed [VALUE_W-1:0]    res_min_ext;
   logic [FILL_W-1:0]            res_cnt_ext;

   // Bring the 32-bit request value to the stored width and back.
   if (DATA_WIDTH <= VALUE_W) begin : g_narrow
      assign push_val    = req.value[DATA_WIDTH-1:0];
      assign res_top_ext = VALUE_W'(signed'(res_top));
      assign res_min_ext = VALUE_W'(signed'(res_min));
   end else begin : g_wide
      assign push_val    = {{(DATA_WIDTH-VALUE_W){req.value[VALUE_W-1]}}, req.value};
      assign res_top_ext = res_top[VALUE_W-1:0];
      assign res_min_ext = res_min[VALUE_W-1:0];
   end

   if (CW <= FILL_W) begin : g_cnt_pad
      assign res_cnt_ext = FILL_W'(res_cnt);
   end else begin : g_cnt_cut
      assign res_cnt_ext = res_cnt[FILL_W-1:0];
   end

   assign req.ready = (state_ff == ST_IDLE) && space_ok;
   assign accept    = req.valid && req.ready;
   assign is_full   = (sp_ff == CW'(DEPTH));
   assign is_zero   = (sp_ff == '0);
   assign sp_dec    = sp_ff - CW'(1);
   assign sp_dec2   = sp_ff - CW'(2);
   assign push_min  = (is_zero || (push_val < min_ff)) ? push_val : min_ff;

   assign wr_addr = sp_ff[AW-1:0];
   assign wr_data = {push_val, push_min};
   assign rd_addr = sp_dec2[AW-1:0];

   always_comb begin
      state_in   = state_ff;
      sp_in      = sp_ff;
      top_in     = top_ff;
      min_in     = min_ff;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      res_valid  = 1'b0;
      res_status = STATUS_OK;
      res_top    = '0;
      res_min    = '0;
      res_cnt    = sp_ff;
      res_empty  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.cmd == CMD_PUSH) begin
                  res_valid = 1'b1;
                  if (is_full) begin
                     res_status = STATUS_OVERFLOW;
                     res_top    = top_ff;
                     res_min    = min_ff;
                  end else begin
                     wr_en   = 1'b1;
                     top_in  = push_val;
                     min_in  = push_min;
                     sp_in   = sp_ff + CW'(1);
                     res_top = push_val;
                     res_min = push_min;
                     res_cnt = sp_ff + CW'(1);
                  end
               end else begin
                  priority if (is_zero) begin
                     res_valid  = 1'b1;
                     res_status = STATUS_UNDERFLOW;
                     res_empty  = 1'b1;
                  end else if (sp_dec == '0) begin
                     res_valid = 1'b1;
                     sp_in     = sp_dec;
                     res_cnt   = sp_dec;
                     res_empty = 1'b1;
                  end else begin
                     // The new top lives in memory; its response follows from ST_POP_WAIT.
                     rd_en    = 1'b1;
                     sp_in    = sp_dec;
                     state_in = ST_POP_WAIT;
                  end
               end
            end
         end
         ST_POP_WAIT: begin
            top_in    = rd_data[2*DATA_WIDTH-1:DATA_WIDTH];
            min_in    = rd_data[DATA_WIDTH-1:0];
            res_valid = 1'b1;
            res_top   = rd_data[2*DATA_WIDTH-1:DATA_WIDTH];
            res_min   = rd_data[DATA_WIDTH-1:0];
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      res.status     = res_status;
      res.top_value  = res_top_ext;
      res.min_value  = res_min_ext;
      res.fill_count = res_cnt_ext;
      res.is_empty   = res_empty;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      min_ff <= min_in;
   end

`ifndef SYNTHESIS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= CW'(DEPTH))
      else $error("entry count exceeds stack depth");

   a_pop_refill_response: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> (state_ff == ST_POP_WAIT) && res_valid)
      else $error("memory refill did not produce a response");

   a_no_accept_in_refill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP_WAIT) |-> !req.ready)
      else $error("transaction accepted during top refill");

   a_overflow_holds_count: assert property (@(posedge clock) disable iff (reset)
      accept && (req.cmd == CMD_PUSH) && is_full |=> $stable(sp_ff))
      else $error("overflowing push changed the entry count");
`endif

endmodule

>>> hw/rtl/min_tracking_stack_core.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_core
// LIFO stack that also reports the smallest value it holds. Each request is a
// push or a pop and yields one response with status, top, minimum and count.
// ----------------------------------------------------------------------------
// Responses: push, overflow, underflow and a pop that empties the stack are
//   buffered on acceptance; a pop that leaves entries answers from ST_POP_WAIT.
// Throughput: one push per cycle while the response buffer has room; a pop that
//   leaves entries holds off requests while the entry memory refills the top.
// Reset: synchronous; clears the entry count, controller state and response
//   buffer. Memory contents are not cleared; only written entries are read.
// ----------------------------------------------------------------------------
module min_tracking_stack_core #(
   parameter int DEPTH      = mts_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = mts_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   mts_req_if.sink   req,
   mts_rsp_if.source rsp
);
   import mts_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                    space_ok;
   logic                    res_valid;
   rsp_type                 res;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [2*DATA_WIDTH-1:0] wr_data;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic [2*DATA_WIDTH-1:0] rd_data;

   mts_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .space_ok  (space_ok),
      .res_valid (res_valid),
      .res       (res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   mts_store #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mts_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .space_ok  (space_ok),
      .rsp       (rsp)
   );

endmodule
